>>> hw/rtl/ptss_pkg.sv
// Shared types and constants for the process table scheduler select block.
// Used by the front, back and top-level modules; depends on nothing.
package ptss_pkg;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SELECT = 2'd2;
	localparam logic [1:0] OP_SPARE  = 2'd3;

	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_SRTF = 2'd2;
	localparam logic [1:0] POL_RR   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  proc_id;
		logic        is_ready;
		logic [31:0] arrive_order;
		logic [31:0] ready_order;
		logic [31:0] total_time;
		logic [31:0] remaining_time;
	} cmd_t;

	typedef struct packed {
		logic       found;
		logic [7:0] selected_id;
		logic [1:0] status;
	} rsp_t;

endpackage

>>> hw/rtl/process_table_scheduler_select_core.sv
// Top level of the process table scheduler select block.
// Depends on ptss_pkg, ptss_cmd_queue and ptss_table_engine.
//
// Channel   | Direction | Handshake              | Content
// s_axis    | in        | tvalid/tready          | command item
// m_axis    | out       | tvalid/tready          | one result per command
// cfg       | in        | cfg_valid/cfg_ready    | policy register
//
// Each command passes through the engine as an accept step, one scan step per
// table entry through a single comparator, and a result step.
// The two-entry queue takes new commands while the engine is busy or stalled, until both entries are full.
// Reset clears the valid bits, the insert counter and the policy to FCFS.
module process_table_scheduler_select_core #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// op[1:0], proc_id[9:2], is_ready[10], arrive_order[42:11],
	// ready_order[74:43], total_time[106:75], remaining_time[138:107], zero pad
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found[0], selected_id[8:1], status[10:9], zero pad
	output logic [15:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_data
);

	logic [1:0]     policy_q;
	ptss_pkg::cmd_t in_cmd;
	ptss_pkg::cmd_t q_cmd;
	ptss_pkg::rsp_t rsp;
	logic           q_valid;
	logic           q_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= ptss_pkg::POL_FCFS;
		end else if (cfg_valid) begin
			policy_q <= cfg_data;
		end
	end

	assign in_cmd.op             = s_axis_tdata[1:0];
	assign in_cmd.proc_id        = s_axis_tdata[9:2];
	assign in_cmd.is_ready       = s_axis_tdata[10];
	assign in_cmd.arrive_order   = s_axis_tdata[42:11];
	assign in_cmd.ready_order    = s_axis_tdata[74:43];
	assign in_cmd.total_time     = s_axis_tdata[106:75];
	assign in_cmd.remaining_time = s_axis_tdata[138:107];

	ptss_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (in_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	ptss_table_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.policy    (policy_q),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.rsp_valid (m_axis_tvalid),
		.rsp_ready (m_axis_tready),
		.rsp       (rsp)
	);

	assign m_axis_tdata = {5'd0, rsp.status, rsp.selected_id, rsp.found};

endmodule

>>> hw/rtl/ptss_cmd_queue.sv
// Two-entry command queue between the front end and the table engine.
// Depends on ptss_pkg for the command type.
module ptss_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ptss_pkg::cmd_t  in_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output ptss_pkg::cmd_t  out_cmd
);

	ptss_pkg::cmd_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (out_valid && out_ready) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({in_valid && in_ready, out_valid && out_ready})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/ptss_table_engine.sv
// Process table and the sequencer that scans it one entry per cycle.
// Depends on ptss_pkg for command, response and code constants.
module ptss_table_engine #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      policy,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  ptss_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ptss_pkg::rsp_t  rsp
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {IDLE, SCAN, RESP} state_t;

	state_t          state_q;
	ptss_pkg::cmd_t  cmd_q;
	logic [CW-1:0]   idx_q;
	logic            hit_q;
	logic [IW-1:0]   hit_slot_q;
	logic            free_q;
	logic [IW-1:0]   free_slot_q;
	logic            best_q;
	logic [7:0]      best_id_q;
	logic [31:0]     best_k1_q;
	logic [31:0]     best_k2_q;
	logic [31:0]     best_stamp_q;
	logic [31:0]     insert_counter_q;
	ptss_pkg::rsp_t  rsp_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [7:0]  id_q        [TABLE_DEPTH];
	logic        rdy_q       [TABLE_DEPTH];
	logic [31:0] arrival_q   [TABLE_DEPTH];
	logic [31:0] rorder_q    [TABLE_DEPTH];
	logic [31:0] total_q     [TABLE_DEPTH];
	logic [31:0] remaining_q [TABLE_DEPTH];
	logic [31:0] stamp_q     [TABLE_DEPTH];

	logic [IW-1:0] idx;
	logic [31:0]   k1;
	logic [31:0]   k2;
	logic          better;
	logic          last;
	logic          hit_now;

	assign idx  = idx_q[IW-1:0];
	assign last = (idx_q == CW'(TABLE_DEPTH - 1));
	assign hit_now = valid_q[idx] && (id_q[idx] == cmd_q.proc_id);

	always_comb begin
		case (policy)
			ptss_pkg::POL_FCFS: begin k1 = arrival_q[idx];   k2 = 32'd0; end
			ptss_pkg::POL_SJF:  begin k1 = total_q[idx];     k2 = arrival_q[idx]; end
			ptss_pkg::POL_SRTF: begin k1 = remaining_q[idx]; k2 = arrival_q[idx]; end
			default:            begin k1 = rorder_q[idx];    k2 = 32'd0; end
		endcase
		if (k1 != best_k1_q) begin
			better = k1 < best_k1_q;
		end else if (k2 != best_k2_q) begin
			better = k2 < best_k2_q;
		end else begin
			better = stamp_q[idx] < best_stamp_q;
		end
	end

	assign cmd_ready = (state_q == IDLE);
	assign rsp_valid = (state_q == RESP);
	assign rsp       = rsp_q;

	// Table writes happen at the last scan step, once the slot is known.
	always_ff @(posedge clk) begin
		if (state_q == SCAN && last && cmd_q.op == ptss_pkg::OP_WRITE) begin
			if (hit_q || hit_now) begin
				rdy_q[hit_now ? idx : hit_slot_q]       <= cmd_q.is_ready;
				arrival_q[hit_now ? idx : hit_slot_q]   <= cmd_q.arrive_order;
				rorder_q[hit_now ? idx : hit_slot_q]    <= cmd_q.ready_order;
				total_q[hit_now ? idx : hit_slot_q]     <= cmd_q.total_time;
				remaining_q[hit_now ? idx : hit_slot_q] <= cmd_q.remaining_time;
			end else if (free_q || !valid_q[idx]) begin
				id_q[free_q ? free_slot_q : idx]        <= cmd_q.proc_id;
				stamp_q[free_q ? free_slot_q : idx]     <= insert_counter_q;
				rdy_q[free_q ? free_slot_q : idx]       <= cmd_q.is_ready;
				arrival_q[free_q ? free_slot_q : idx]   <= cmd_q.arrive_order;
				rorder_q[free_q ? free_slot_q : idx]    <= cmd_q.ready_order;
				total_q[free_q ? free_slot_q : idx]     <= cmd_q.total_time;
				remaining_q[free_q ? free_slot_q : idx] <= cmd_q.remaining_time;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= IDLE;
			valid_q          <= '0;
			insert_counter_q <= 32'd0;
			idx_q            <= '0;
			hit_q            <= 1'b0;
			free_q           <= 1'b0;
			best_q           <= 1'b0;
			hit_slot_q       <= '0;
			free_slot_q      <= '0;
			best_id_q        <= 8'd0;
			best_k1_q        <= 32'd0;
			best_k2_q        <= 32'd0;
			best_stamp_q     <= 32'd0;
			cmd_q            <= '0;
			rsp_q            <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						idx_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						best_q  <= 1'b0;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (hit_now && !hit_q) begin
						hit_q      <= 1'b1;
						hit_slot_q <= idx;
					end
					if (!valid_q[idx] && !free_q) begin
						free_q      <= 1'b1;
						free_slot_q <= idx;
					end
					if (valid_q[idx] && rdy_q[idx] && (!best_q || better)) begin
						best_q       <= 1'b1;
						best_id_q    <= id_q[idx];
						best_k1_q    <= k1;
						best_k2_q    <= k2;
						best_stamp_q <= stamp_q[idx];
					end
					idx_q <= idx_q + CW'(1);
					if (last) begin
						state_q <= RESP;
						case (cmd_q.op)
							ptss_pkg::OP_WRITE: begin
								if (hit_q || hit_now) begin
									rsp_q <= '0;
								end else if (free_q || !valid_q[idx]) begin
									valid_q[free_q ? free_slot_q : idx] <= 1'b1;
									insert_counter_q <= insert_counter_q + 32'd1;
									rsp_q <= '0;
								end else begin
									rsp_q <= {1'b0, 8'd0, ptss_pkg::ST_FULL};
								end
							end
							ptss_pkg::OP_REMOVE: begin
								if (hit_q || hit_now) begin
									valid_q[hit_q ? hit_slot_q : idx] <= 1'b0;
									rsp_q <= '0;
								end else begin
									rsp_q <= {1'b0, 8'd0, ptss_pkg::ST_NOT_FOUND};
								end
							end
							ptss_pkg::OP_SELECT: begin
								if (valid_q[idx] && rdy_q[idx] && (!best_q || better)) begin
									rsp_q <= {1'b1, id_q[idx], ptss_pkg::ST_OK};
								end else if (best_q) begin
									rsp_q <= {1'b1, best_id_q, ptss_pkg::ST_OK};
								end else begin
									rsp_q <= '0;
								end
							end
							default: rsp_q <= '0;
						endcase
					end
				end
				RESP: begin
					if (rsp_ready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> sim/process_table_scheduler_select_core_tb.sv
// Self-checking testbench for the process table scheduler select block.
// Depends on ptss_pkg and the RTL of process_table_scheduler_select_core.
`timescale 1ns / 1ps

module process_table_scheduler_select_core_tb;

	localparam int DEPTH = 16;
	localparam int ENGINE_CYCLES = DEPTH + 2;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [15:0]  m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_data;

	process_table_scheduler_select_core #(.TABLE_DEPTH(DEPTH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the process table.
	logic        tbl_valid [DEPTH];
	logic [7:0]  tbl_id [DEPTH];
	logic        tbl_ready [DEPTH];
	logic [31:0] tbl_arrival [DEPTH];
	logic [31:0] tbl_rseq [DEPTH];
	logic [31:0] tbl_total [DEPTH];
	logic [31:0] tbl_remain [DEPTH];
	logic [31:0] tbl_stamp [DEPTH];
	logic [31:0] stamp_counter;
	logic [1:0]  cur_policy;

	ptss_pkg::cmd_t cmd_queue[$];
	ptss_pkg::rsp_t rsp_queue[$];
	int   errors;
	int   send_wait;
	int   recv_wait;

	initial begin
		clk = 1'b0;
	end
	always #2 clk = ~clk;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic bit wins(input int c, input int s);
		logic [31:0] c1, c2, s1, s2;
		c2 = '0;
		s2 = '0;
		case (cur_policy)
			ptss_pkg::POL_FCFS: begin
				c1 = tbl_arrival[c];
				s1 = tbl_arrival[s];
			end
			ptss_pkg::POL_SJF: begin
				c1 = tbl_total[c];
				s1 = tbl_total[s];
				c2 = tbl_arrival[c];
				s2 = tbl_arrival[s];
			end
			ptss_pkg::POL_SRTF: begin
				c1 = tbl_remain[c];
				s1 = tbl_remain[s];
				c2 = tbl_arrival[c];
				s2 = tbl_arrival[s];
			end
			default: begin
				c1 = tbl_rseq[c];
				s1 = tbl_rseq[s];
			end
		endcase
		if (c1 != s1)
			return c1 < s1;
		if (c2 != s2)
			return c2 < s2;
		return tbl_stamp[c] < tbl_stamp[s];
	endfunction

	function automatic int lookup(input logic [7:0] id);
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[i] && tbl_id[i] == id)
				return i;
		return -1;
	endfunction

	// Applies one accepted command to the shadow table and returns its result.
	function automatic ptss_pkg::rsp_t schedule_step(input ptss_pkg::cmd_t c);
		ptss_pkg::rsp_t r;
		int slot;
		int best;
		r = '0;
		best = -1;
		case (c.op)
			ptss_pkg::OP_WRITE: begin
				slot = lookup(c.proc_id);
				if (slot < 0) begin
					for (int i = 0; i < DEPTH; i++)
						if (!tbl_valid[i] && slot < 0)
							slot = i;
					if (slot >= 0) begin
						tbl_valid[slot] = 1'b1;
						tbl_id[slot] = c.proc_id;
						tbl_stamp[slot] = stamp_counter;
						stamp_counter = stamp_counter + 32'd1;
					end
				end
				if (slot < 0) begin
					r.status = ptss_pkg::ST_FULL;
				end else begin
					tbl_ready[slot] = c.is_ready;
					tbl_arrival[slot] = c.arrive_order;
					tbl_rseq[slot] = c.ready_order;
					tbl_total[slot] = c.total_time;
					tbl_remain[slot] = c.remaining_time;
				end
			end
			ptss_pkg::OP_REMOVE: begin
				slot = lookup(c.proc_id);
				if (slot < 0)
					r.status = ptss_pkg::ST_NOT_FOUND;
				else
					tbl_valid[slot] = 1'b0;
			end
			ptss_pkg::OP_SELECT: begin
				for (int i = 0; i < DEPTH; i++)
					if (tbl_valid[i] && tbl_ready[i])
						if (best < 0 || wins(i, best))
							best = i;
				if (best >= 0) begin
					r.found = 1'b1;
					r.selected_id = tbl_id[best];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Random command. Ids come from a small pool so that updates, removes and
	// a full table all happen often; small key ranges force ties.
	function automatic ptss_pkg::cmd_t rand_cmd();
		ptss_pkg::cmd_t c;
		int k;
		k = $urandom_range(0, 99);
		c.op = (k < 45) ? ptss_pkg::OP_WRITE : (k < 65) ? ptss_pkg::OP_REMOVE :
			(k < 97) ? ptss_pkg::OP_SELECT : ptss_pkg::OP_SPARE;
		c.proc_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
		c.is_ready = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 1)) begin
			c.arrive_order = $urandom_range(0, 7);
			c.ready_order = $urandom_range(0, 7);
			c.total_time = $urandom_range(0, 7);
			c.remaining_time = $urandom_range(0, 7);
		end else begin
			c.arrive_order = $urandom;
			c.ready_order = $urandom;
			c.total_time = $urandom;
			c.remaining_time = $urandom;
		end
		return c;
	endfunction

	function automatic ptss_pkg::cmd_t make_cmd(input logic [1:0] op, input logic [7:0] id,
			input logic rdy, input logic [31:0] a, input logic [31:0] q,
			input logic [31:0] t, input logic [31:0] rem);
		ptss_pkg::cmd_t c;
		c.op = op;
		c.proc_id = id;
		c.is_ready = rdy;
		c.arrive_order = a;
		c.ready_order = q;
		c.total_time = t;
		c.remaining_time = rem;
		return c;
	endfunction

	task automatic write_policy(input logic [1:0] p);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= p;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_policy = p;
	endtask

	// Waits for the block to drain before a register write.
	task automatic drain();
		while (cmd_queue.size() != 0 || s_axis_tvalid || rsp_queue.size() != 0)
			@(posedge clk);
		repeat (2 * ENGINE_CYCLES) @(posedge clk);
	endtask

	// Driver: one transfer per queued command, with a random gap after each.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_wait <= 0;
		end else if (s_axis_tvalid && !s_axis_tready) begin
		end else if (s_axis_tvalid && send_wait == 0 && cmd_queue.size() == 0) begin
			s_axis_tvalid <= 1'b0;
		end else if (send_wait > 0) begin
			s_axis_tvalid <= 1'b0;
			send_wait <= send_wait - 1;
		end else if (cmd_queue.size() != 0) begin
			s_axis_tdata <= {5'd0, cmd_queue[0].remaining_time, cmd_queue[0].total_time,
				cmd_queue[0].ready_order, cmd_queue[0].arrive_order, cmd_queue[0].is_ready,
				cmd_queue[0].proc_id, cmd_queue[0].op};
			rsp_queue.push_back(schedule_step(cmd_queue.pop_front()));
			s_axis_tvalid <= 1'b1;
			send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Monitor: checks every result transfer and draws a new stall after each.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_wait <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (rsp_queue.size() == 0) begin
				report("unexpected result", 32'(m_axis_tdata), 0);
			end else begin
				if (m_axis_tdata[0] !== rsp_queue[0].found)
					report("found", 32'(m_axis_tdata[0]), 32'(rsp_queue[0].found));
				if (m_axis_tdata[8:1] !== rsp_queue[0].selected_id)
					report("selected_id", 32'(m_axis_tdata[8:1]),
						32'(rsp_queue[0].selected_id));
				if (m_axis_tdata[10:9] !== rsp_queue[0].status)
					report("status", 32'(m_axis_tdata[10:9]), 32'(rsp_queue[0].status));
				void'(rsp_queue.pop_front());
			end
			recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else if (recv_wait > 0) begin
			recv_wait <= recv_wait - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		logic [1:0] policies [4];
		errors = 0;
		stamp_counter = '0;
		cur_policy = ptss_pkg::POL_FCFS;
		for (int i = 0; i < DEPTH; i++)
			tbl_valid[i] = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset policy: empty select, missing id,
		// extreme field values, update in place, full table and unused op.
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_SELECT, 8'd0, 1'b0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_REMOVE, 8'hff, 1'b0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_WRITE, 8'hff, 1'b1, '1, '1, '1, '1));
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_WRITE, 8'h00, 1'b1, '1, 0, 0, 0));
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_SELECT, 8'h00, 1'b0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_WRITE, 8'hff, 1'b0, 0, 5, 5, 5));
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_SELECT, 8'h00, 1'b0, 0, 0, 0, 0));
		for (int i = 1; i <= 15; i++)
			cmd_queue.push_back(make_cmd(ptss_pkg::OP_WRITE, 8'(i), 1'b1, 3, 3, 3, 3));
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_SELECT, 8'h00, 1'b0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_SPARE, 8'haa, 1'b1, '1, '1, '1, '1));
		cmd_queue.push_back(make_cmd(ptss_pkg::OP_REMOVE, 8'hff, 1'b0, 0, 0, 0, 0));
		drain();

		// Random phases cycle through every policy, then draw policies at random.
		policies = '{ptss_pkg::POL_RR, ptss_pkg::POL_SJF, ptss_pkg::POL_SRTF,
			ptss_pkg::POL_FCFS};
		for (int ph = 0; ph < 8; ph++) begin
			write_policy((ph < 4) ? policies[ph] : 2'($urandom));
			for (int n = 0; n < 175; n++)
				cmd_queue.push_back(rand_cmd());
			drain();
		end

		if (errors == 0)
			$display("process_table_scheduler_select_core test passed");
		else
			$display("process_table_scheduler_select_core test failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("process_table_scheduler_select_core test failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ptss_pkg.sv
hw/rtl/ptss_cmd_queue.sv
hw/rtl/ptss_table_engine.sv
hw/rtl/process_table_scheduler_select_core.sv
sim/process_table_scheduler_select_core_tb.sv
